FILE: sv/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

  // field widths
  localparam int unsigned ModeW  = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 7;
  localparam int unsigned BinW   = 32;
  localparam int unsigned BcdW   = 40;
  localparam int unsigned RemW   = 7;

  // mode codes
  localparam logic [ModeW-1:0] MODE_SDEC  = 3'd0;
  localparam logic [ModeW-1:0] MODE_UDEC  = 3'd1;
  localparam logic [ModeW-1:0] MODE_HEX32 = 3'd2;
  localparam logic [ModeW-1:0] MODE_HEX64 = 3'd3;
  localparam logic [ModeW-1:0] MODE_BIN   = 3'd4;

  // fixed characters
  localparam logic [CharW-1:0] CH_MINUS = 7'h2d;
  localparam logic [CharW-1:0] CH_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CH_X     = 7'h78;

  // digit counts
  localparam logic [RemW-1:0] DEC_DIGITS   = 7'd10;
  localparam logic [RemW-1:0] HEX32_DIGITS = 7'd8;
  localparam logic [RemW-1:0] HEX64_DIGITS = 7'd16;
  localparam logic [RemW-1:0] BIN_DIGITS   = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // status of the binary to bcd converter
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // lowercase hex character of one nibble
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'ha: c = 7'h61;
      4'hb: c = 7'h62;
      4'hc: c = 7'h63;
      4'hd: c = 7'h64;
      4'he: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2a_if.sv
`default_nettype none

// input channel: one integer and its print mode
interface i2a_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::ModeW-1:0]     mode;
  logic [i2a_pkg::ValueW-1:0]    value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// result channel: one character per transfer
interface i2a_out_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::CharW-1:0]     char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/i2a_dabble.sv
`default_nettype none

// binary to bcd, one input bit per cycle (shift and add three)
module i2a_dabble (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [i2a_pkg::BinW-1:0]     bin,
  output i2a_pkg::dab_stat_t                stat,
  output logic [i2a_pkg::BcdW-1:0]          bcd
);

  localparam int unsigned NDig = i2a_pkg::BcdW / 4;
  localparam int unsigned CntW = $clog2(i2a_pkg::BinW);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [i2a_pkg::BinW-1:0]    bin_r, bin_nxt;
  logic [i2a_pkg::BcdW-1:0]    bcd_r, bcd_nxt;
  logic [i2a_pkg::BcdW-1:0]    adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  // iteration control
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      bin_nxt = bin;
      bcd_nxt = '0;
    end else if (run_r) begin
      bcd_nxt = {adj[i2a_pkg::BcdW-2:0], bin_r[i2a_pkg::BinW-1]};
      bin_nxt = {bin_r[i2a_pkg::BinW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(i2a_pkg::BinW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

`default_nettype wire

FILE: sv/integer_to_ascii_formatter_core.sv
// sequence: decimal modes run the bcd conversion, then skip leading zeros (up to 9),
// then emit the characters; hex modes go from the transfer to the prefix state and emit;
// binary mode drops up to 63 leading zeros in the skip stage before emitting.
// throughput: one character per cycle while emitting, unless the result channel stalls;
// the next item is taken once the final character is in the output register.
// reset: synchronous active low, clears state.
`default_nettype none

module integer_to_ascii_formatter_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  i2a_in_if.sink          in_ch,
  i2a_out_if.source       out_ch
);

  i2a_pkg::state_t                   state_r, state_nxt;
  logic [i2a_pkg::ValueW-1:0]        sh_r, sh_nxt;
  logic [i2a_pkg::RemW-1:0]          rem_r, rem_nxt;
  logic                              nib_r, nib_nxt;
  logic                              skip_r, skip_nxt;
  logic                              hex_r, hex_nxt;
  logic [1:0]                        pfx_r, pfx_nxt;
  logic                              neg_r, neg_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [i2a_pkg::CharW-1:0]         out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              in_xfer;
  logic                              slot_free;
  logic                              dab_start;
  logic [i2a_pkg::BinW-1:0]          low;
  logic [i2a_pkg::BinW-1:0]          mag;
  logic                              val_neg;
  i2a_pkg::dab_stat_t                dab_stat;
  logic [i2a_pkg::BcdW-1:0]          dab_bcd;
  logic [i2a_pkg::ValueW-1:0]        sh_next_digit;
  logic                              top_zero;
  logic [i2a_pkg::CharW-1:0]         top_char;

  assign in_ch.ready = (state_r == i2a_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // magnitude for the decimal modes
  assign low     = in_ch.value[i2a_pkg::BinW-1:0];
  assign val_neg = (in_ch.mode == i2a_pkg::MODE_SDEC) && low[i2a_pkg::BinW-1];
  assign mag     = val_neg ? (i2a_pkg::BinW'(0) - low) : low;

  i2a_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .bin   (mag),
    .stat  (dab_stat),
    .bcd   (dab_bcd)
  );

  // digit shift register view
  assign sh_next_digit = nib_r ? {sh_r[i2a_pkg::ValueW-5:0], 4'h0}
                               : {sh_r[i2a_pkg::ValueW-2:0], 1'b0};
  assign top_zero = nib_r ? (sh_r[i2a_pkg::ValueW-1 -: 4] == 4'h0) : !sh_r[i2a_pkg::ValueW-1];
  assign top_char = nib_r ? i2a_pkg::hex_char(sh_r[i2a_pkg::ValueW-1 -: 4])
                          : i2a_pkg::hex_char({3'b000, sh_r[i2a_pkg::ValueW-1]});

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    nib_nxt       = nib_r;
    skip_nxt      = skip_r;
    hex_nxt       = hex_r;
    pfx_nxt       = pfx_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    dab_start     = 1'b0;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.mode)
            i2a_pkg::MODE_SDEC, i2a_pkg::MODE_UDEC: begin
              dab_start = 1'b1;
              neg_nxt   = val_neg;
              hex_nxt   = 1'b0;
              pfx_nxt   = 2'd1;
              state_nxt = i2a_pkg::ST_CONV;
            end
            i2a_pkg::MODE_HEX32: begin
              sh_nxt    = {low, {i2a_pkg::BinW{1'b0}}};
              rem_nxt   = i2a_pkg::HEX32_DIGITS;
              nib_nxt   = 1'b1;
              skip_nxt  = 1'b0;
              hex_nxt   = 1'b1;
              pfx_nxt   = 2'd2;
              state_nxt = i2a_pkg::ST_PRE;
            end
            i2a_pkg::MODE_HEX64: begin
              sh_nxt    = in_ch.value;
              rem_nxt   = i2a_pkg::HEX64_DIGITS;
              nib_nxt   = 1'b1;
              skip_nxt  = 1'b0;
              hex_nxt   = 1'b1;
              pfx_nxt   = 2'd2;
              state_nxt = i2a_pkg::ST_PRE;
            end
            i2a_pkg::MODE_BIN: begin
              sh_nxt    = in_ch.value;
              rem_nxt   = i2a_pkg::BIN_DIGITS;
              nib_nxt   = 1'b0;
              skip_nxt  = 1'b1;
              state_nxt = i2a_pkg::ST_SKIP;
            end
            default: begin
              state_nxt = i2a_pkg::ST_IDLE;
            end
          endcase
        end
      end
      i2a_pkg::ST_CONV: begin
        if (dab_stat.done) begin
          sh_nxt    = {dab_bcd, {(i2a_pkg::ValueW - i2a_pkg::BcdW){1'b0}}};
          rem_nxt   = i2a_pkg::DEC_DIGITS;
          nib_nxt   = 1'b1;
          skip_nxt  = 1'b1;
          state_nxt = neg_r ? i2a_pkg::ST_PRE : i2a_pkg::ST_SKIP;
        end
      end
      i2a_pkg::ST_PRE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (hex_r) begin
            out_char_nxt = (pfx_r == 2'd2) ? i2a_pkg::CH_ZERO : i2a_pkg::CH_X;
          end else begin
            out_char_nxt = i2a_pkg::CH_MINUS;
          end
          pfx_nxt = pfx_r - 2'd1;
          if (pfx_r == 2'd1) begin
            state_nxt = skip_r ? i2a_pkg::ST_SKIP : i2a_pkg::ST_EMIT;
          end
        end
      end
      i2a_pkg::ST_SKIP: begin
        if (top_zero && (rem_r > i2a_pkg::RemW'(1))) begin
          sh_nxt  = sh_next_digit;
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = i2a_pkg::ST_EMIT;
        end
      end
      i2a_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = top_char;
          out_last_nxt  = (rem_r == i2a_pkg::RemW'(1));
          sh_nxt        = sh_next_digit;
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == i2a_pkg::RemW'(1)) begin
            state_nxt = i2a_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i2a_pkg::ST_IDLE;
      end
    endcase
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2a_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    nib_r      <= nib_nxt;
    skip_r     <= skip_nxt;
    hex_r      <= hex_nxt;
    pfx_r      <= pfx_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  // converter finishes only while the state machine waits for it
  a_dab_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab_stat.done |-> (state_r == i2a_pkg::ST_CONV))
    else $error("bcd conversion finished outside conversion state");

  // converter shifts only during the conversion state
  a_dab_busy_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab_stat.busy |-> (state_r == i2a_pkg::ST_CONV))
    else $error("bcd conversion running outside conversion state");

  // digit count never runs dry while digits are pending
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == i2a_pkg::ST_SKIP) || (state_r == i2a_pkg::ST_EMIT)) |-> (rem_r != '0))
    else $error("digit count empty while emitting");

  // the final digit returns the machine to idle with last set
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == i2a_pkg::ST_EMIT) && slot_free && (rem_r == i2a_pkg::RemW'(1)))
    |=> ((state_r == i2a_pkg::ST_IDLE) && out_valid_r && out_last_r))
    else $error("final digit did not close the item");

  // a hex transfer always starts with the prefix
  a_hex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && ((in_ch.mode == i2a_pkg::MODE_HEX32) || (in_ch.mode == i2a_pkg::MODE_HEX64)))
    |=> ((state_r == i2a_pkg::ST_PRE) && hex_r && (pfx_r == 2'd2)))
    else $error("hex item did not enter prefix state");

endmodule

`default_nettype wire

FILE: tb/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

// predicted character stream and its comparison against the result channel
class text_scoreboard;
  typedef struct packed {
    logic [i2a_pkg::CharW-1:0] code;
    logic                      last;
  } char_t;

  localparam logic [i2a_pkg::CharW-1:0] CH_A_LOWER = 7'h61;

  char_t expected_text[$];
  int    errors;
  int    chars_ok;
  int    numbers_by_mode[8];

  function new();
    errors   = 0;
    chars_ok = 0;
    foreach (numbers_by_mode[i]) numbers_by_mode[i] = 0;
  endfunction

  function logic [i2a_pkg::CharW-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) return i2a_pkg::CH_ZERO + 7'(d);
    return CH_A_LOWER + 7'(d - 4'd10);
  endfunction

  // render one accepted number into its expected characters
  function void note_number(input logic [i2a_pkg::ModeW-1:0] mode,
                            input logic [i2a_pkg::ValueW-1:0] value);
    char_t       txt[$];
    logic [3:0]  digits[$];
    logic [31:0] mag;
    int          top;
    int          n;
    numbers_by_mode[mode]++;
    mag = value[31:0];
    case (mode)
      i2a_pkg::MODE_SDEC, i2a_pkg::MODE_UDEC: begin
        // minus sign then magnitude; the most negative value wraps to itself
        if (mode == i2a_pkg::MODE_SDEC && mag[31]) begin
          txt.push_back({i2a_pkg::CH_MINUS, 1'b0});
          mag = -mag;
        end
        do begin
          digits.push_front(4'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 32'd0);
        foreach (digits[i]) txt.push_back({digit_char(digits[i]), 1'b0});
      end
      i2a_pkg::MODE_HEX32, i2a_pkg::MODE_HEX64: begin
        n = (mode == i2a_pkg::MODE_HEX32) ? 8 : 16;
        txt.push_back({i2a_pkg::CH_ZERO, 1'b0});
        txt.push_back({i2a_pkg::CH_X, 1'b0});
        for (int i = n - 1; i >= 0; i--) txt.push_back({digit_char(value[i*4 +: 4]), 1'b0});
      end
      i2a_pkg::MODE_BIN: begin
        // leading zeros dropped, a lone zero still prints
        top = 0;
        for (int i = 63; i > 0; i--) begin
          if (value[i]) begin
            top = i;
            break;
          end
        end
        for (int i = top; i >= 0; i--) txt.push_back({digit_char({3'b000, value[i]}), 1'b0});
      end
      default: ;
    endcase
    if (txt.size() > 0) txt[txt.size()-1].last = 1'b1;
    foreach (txt[i]) expected_text.push_back(txt[i]);
  endfunction

  // compare one accepted character against the oldest expectation
  function void check_char(input logic [i2a_pkg::CharW-1:0] code, input logic last);
    char_t want;
    if (expected_text.size() == 0) begin
      errors++;
      $display("%0t: unexpected char expected none actual 0x%02h last %0b", $time, code, last);
      return;
    end
    want = expected_text.pop_front();
    if (want.code !== code) begin
      errors++;
      $display("%0t: char_code mismatch expected 0x%02h actual 0x%02h",
               $time, want.code, code);
    end
    if (want.last !== last) begin
      errors++;
      $display("%0t: last mismatch expected %0b actual %0b", $time, want.last, last);
    end
    if (want.code === code && want.last === last) chars_ok++;
  endfunction

  function int pending();
    return expected_text.size();
  endfunction
endclass

module tb_integer_to_ascii_formatter_core;

  localparam int unsigned RANDOM_NUMBERS = 280;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  localparam logic [i2a_pkg::ModeW-1:0] MODE_FIRST_UNUSED = 3'd5;

  logic clk;
  logic rst_n;
  logic in_idle_on;
  logic out_idle_on;
  int   idle_cycles;
  int   ignored_sent;

  text_scoreboard sb;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  integer_to_ascii_formatter_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_number(in_ch.mode, in_ch.value);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_char(out_ch.char_code, out_ch.last);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall before each character
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = out_idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // one number on the input channel, optionally held back until the output drains
  task automatic send_number(input logic [i2a_pkg::ModeW-1:0] m,
                             input logic [i2a_pkg::ValueW-1:0] v,
                             input bit hold);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (hold) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // values biased towards digit-count and sign boundaries
  function automatic logic [i2a_pkg::ValueW-1:0] rand_value();
    logic [i2a_pkg::ValueW-1:0] v;
    logic [31:0]                p;
    int                         k;
    v = {$urandom, $urandom};
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: ;
      1: v = 64'($urandom_range(0, 20));
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~64'd0 >> $urandom_range(0, 63);
      4: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        v[31:0] = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) v[31:0] = 32'd0 - 32'($urandom_range(0, 20));
        else v[31:0] = 32'h8000_0000 + 32'($urandom_range(0, 3));
      end
    endcase
    return v;
  endfunction

  // main sequence
  initial begin
    logic [i2a_pkg::ModeW-1:0] m;
    int                        sent;
    sb           = new();
    rst_n        = 1'b0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    idle_cycles  = 0;
    ignored_sent = 0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = i2a_pkg::MODE_SDEC;
    in_ch.value  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and special cases of each mode
    send_number(i2a_pkg::MODE_SDEC, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'd1, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'h0000_0000_7fff_ffff, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'h0000_0000_8000_0000, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'hdead_beef_0000_007b, 1'b0);
    send_number(i2a_pkg::MODE_UDEC, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_UDEC, 64'h0000_0000_ffff_ffff, 1'b0);
    send_number(i2a_pkg::MODE_UDEC, 64'hffff_ffff_3b9a_ca00, 1'b0);
    send_number(i2a_pkg::MODE_UDEC, 64'd9, 1'b0);
    send_number(i2a_pkg::MODE_HEX32, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_HEX32, 64'hffff_ffff_89ab_cdef, 1'b0);
    send_number(i2a_pkg::MODE_HEX64, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_HEX64, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_number(i2a_pkg::MODE_HEX64, 64'h0123_4567_89ab_cdef, 1'b0);
    send_number(i2a_pkg::MODE_BIN, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_BIN, 64'd1, 1'b0);
    send_number(i2a_pkg::MODE_BIN, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_number(i2a_pkg::MODE_BIN, 64'h8000_0000_0000_0000, 1'b0);
    send_number(MODE_FIRST_UNUSED, 64'h1234, 1'b0);
    send_number(MODE_FIRST_UNUSED + 3'd1, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_number(MODE_FIRST_UNUSED + 3'd2, 64'd0, 1'b0);
    send_number(i2a_pkg::MODE_SDEC, 64'd42, 1'b0);
    ignored_sent = 3;

    // random: four quarters with different idling on each side
    sent = 0;
    while (sent < RANDOM_NUMBERS) begin
      in_idle_on  = (sent / (RANDOM_NUMBERS / 4)) inside {0, 2};
      out_idle_on = (sent / (RANDOM_NUMBERS / 4)) inside {0, 3};
      if ($urandom_range(0, 19) == 0) begin
        m = MODE_FIRST_UNUSED + 3'($urandom_range(0, 2));
        ignored_sent++;
      end else begin
        m = 3'($urandom_range(i2a_pkg::MODE_SDEC, i2a_pkg::MODE_BIN));
        sent++;
      end
      send_number(m, rand_value(), sent == RANDOM_NUMBERS / 2 + 7);
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for any stray characters
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("numbers by mode sdec/udec/hex32/hex64/bin: %0d/%0d/%0d/%0d/%0d, unused codes %0d",
             sb.numbers_by_mode[i2a_pkg::MODE_SDEC], sb.numbers_by_mode[i2a_pkg::MODE_UDEC],
             sb.numbers_by_mode[i2a_pkg::MODE_HEX32], sb.numbers_by_mode[i2a_pkg::MODE_HEX64],
             sb.numbers_by_mode[i2a_pkg::MODE_BIN], ignored_sent);
    $display("characters matched %0d, mismatches %0d", sb.chars_ok, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/i2a_pkg.sv
sv/i2a_if.sv
sv/i2a_dabble.sv
sv/integer_to_ascii_formatter_core.sv
tb/tb_integer_to_ascii_formatter_core.sv
